/* rtl/tsig_pkg.sv */
`timescale 1ns / 1ps
// Shared widths, register indexes, phase codes and state types for the
// trapezoid step interval generator. No dependencies.

package tsig_pkg;

    // Default fixed-point positions
    localparam int TICK_FRAC_BITS_DEF = 16;
    localparam int HZ_FRAC_BITS_DEF   = 8;

    // Field widths
    localparam int RATE_W      = 28;   // step rate in Hz, fixed point
    localparam int SPAN_W      = 40;   // phase lengths in ticks
    localparam int IVL_W       = 32;   // issued interval
    localparam int TICK_RATE_W = 27;   // timer tick frequency
    localparam int ELAPSED_W   = 42;   // profile time
    localparam int RES_W       = 34;   // signed tick residual
    localparam int HZ_OUT_W    = 20;   // integer step rate out
    localparam int PHASE_W     = 2;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 40;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_HZ   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_HZ = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CRUISE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DECEL     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_IVL   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_IVL   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_TICK_RATE = 3'd7;

    // Register reset values
    localparam logic [RATE_W-1:0]      BASE_HZ_RST   = 28'd51200;
    localparam logic [RATE_W-1:0]      TARGET_HZ_RST = 28'd27306666;
    localparam logic [SPAN_W-1:0]      ACCEL_RST     = 40'd100000000;
    localparam logic [SPAN_W-1:0]      CRUISE_RST    = 40'd30000000;
    localparam logic [SPAN_W-1:0]      DECEL_RST     = 40'd100000000;
    localparam logic [IVL_W-1:0]       MIN_IVL_RST   = 32'd1;
    localparam logic [IVL_W-1:0]       MAX_IVL_RST   = 32'hFFFF_FFFF;
    localparam logic [TICK_RATE_W-1:0] TICK_RATE_RST = 27'd10000000;

    // Profile phase codes
    localparam logic [PHASE_W-1:0] PHASE_ACCEL  = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_CRUISE = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_DECEL  = 2'd2;

    // Residual saturation limits
    localparam logic [RES_W-1:0] RES_MAX = {1'b0, {(RES_W-1){1'b1}}};
    localparam logic [RES_W-1:0] RES_MIN = {1'b1, {(RES_W-1){1'b0}}};

    // Sequencer of the top level
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUM,
        ST_CHECK,
        ST_RAMP,
        ST_RATE,
        ST_LAUNCH,
        ST_DIV,
        ST_ROUND,
        ST_CLAMP,
        ST_UPDATE,
        ST_FINISH,
        ST_EMIT
    } top_state_t;

    // Ramp term unit: shift-add multiply, then restoring divide
    typedef enum logic [1:0] {
        RS_IDLE,
        RS_MUL,
        RS_DIV
    } ramp_state_t;

    // Period divider
    typedef enum logic {
        DS_IDLE,
        DS_RUN
    } div_state_t;

endpackage

/* rtl/tsig_ramp_unit.sv */
`timescale 1ns / 1ps
// Ramp term unit: floor(mag * t / len), one multiplier bit then one quotient
// bit per clock in a single shared shift register. Uses tsig_pkg.

module tsig_ramp_unit
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [tsig_pkg::RATE_W-1:0] mag,
    input  logic [tsig_pkg::SPAN_W-1:0] t,
    input  logic [tsig_pkg::SPAN_W-1:0] len,
    output logic                        done,
    output logic [tsig_pkg::RATE_W-1:0] term
);
    import tsig_pkg::*;

    localparam int ACC_W = SPAN_W + RATE_W;
    localparam int CNT_W = $clog2(RATE_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(RATE_W - 1);

    ramp_state_t       state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [SPAN_W-1:0] t_reg, t_next;
    logic [SPAN_W-1:0] len_reg, len_next;

    logic [SPAN_W:0]   mul_hi;
    logic [SPAN_W:0]   div_shift;
    logic [SPAN_W+1:0] div_diff;
    logic              div_borrow;
    logic [SPAN_W-1:0] div_rem;

    // Step logic: add t under the low multiplier bit, or trial-subtract len
    assign mul_hi     = {1'b0, acc_reg[ACC_W-1:RATE_W]}
                      + (acc_reg[0] ? {1'b0, t_reg} : {(SPAN_W+1){1'b0}});
    assign div_shift  = {acc_reg[ACC_W-1:RATE_W], acc_reg[RATE_W-1]};
    assign div_diff   = {1'b0, div_shift} - {2'b00, len_reg};
    assign div_borrow = div_diff[SPAN_W+1];
    assign div_rem    = div_borrow ? div_shift[SPAN_W-1:0] : div_diff[SPAN_W-1:0];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            RS_IDLE:
            begin
                if (start)
                    state_next = RS_MUL;
            end
            RS_MUL:
            begin
                if (cnt_reg == '0)
                    state_next = RS_DIV;
            end
            RS_DIV:
            begin
                if (cnt_reg == '0)
                    state_next = RS_IDLE;
            end
            default:
                state_next = RS_IDLE;
        endcase
    end

    // Outputs: quotient sits in the low bits once the last divide step lands
    always_comb
    begin
        done = (state_reg == RS_DIV) && (cnt_reg == '0);
        term = acc_reg[RATE_W-1:0];
    end

    // Datapath
    always_comb
    begin
        acc_next = acc_reg;
        cnt_next = cnt_reg;
        t_next   = t_reg;
        len_next = len_reg;
        unique case (state_reg)
            RS_IDLE:
            begin
                if (start)
                begin
                    acc_next = {{SPAN_W{1'b0}}, mag};
                    t_next   = t;
                    len_next = len;
                    cnt_next = CNT_LAST;
                end
            end
            RS_MUL:
            begin
                acc_next = {mul_hi, acc_reg[RATE_W-1:1]};
                cnt_next = (cnt_reg == '0) ? CNT_LAST : cnt_reg - 1'b1;
            end
            RS_DIV:
            begin
                acc_next = {div_rem, acc_reg[RATE_W-2:0], ~div_borrow};
                if (cnt_reg != '0)
                    cnt_next = cnt_reg - 1'b1;
            end
            default:
                ;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= RS_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Operand registers
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        t_reg   <= t_next;
        len_reg <= len_next;
    end

endmodule

/* rtl/tsig_div_unit.sv */
`timescale 1ns / 1ps
// Period divider: floor(tick_rate * 2^(TICK_FRAC_BITS+HZ_FRAC_BITS) / rate),
// restoring, one quotient bit per clock. Uses tsig_pkg.

module tsig_div_unit
#(
    parameter int TICK_FRAC_BITS = tsig_pkg::TICK_FRAC_BITS_DEF,
    parameter int HZ_FRAC_BITS   = tsig_pkg::HZ_FRAC_BITS_DEF
)
(
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        start,
    input  logic [tsig_pkg::TICK_RATE_W-1:0]            tick_rate,
    input  logic [tsig_pkg::RATE_W-1:0]                 rate,
    output logic                                        done,
    output logic [tsig_pkg::TICK_RATE_W+TICK_FRAC_BITS-1:0] quot
);
    import tsig_pkg::*;

    // Rate is at least 1 Hz, so the quotient needs no more than QW bits and
    // the top HZ_FRAC_BITS of the numerator start as the remainder.
    localparam int QW    = TICK_RATE_W + TICK_FRAC_BITS;
    localparam int NW    = QW + HZ_FRAC_BITS;
    localparam int CNT_W = $clog2(QW);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QW - 1);

    div_state_t        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [RATE_W-1:0] rem_reg, rem_next;
    logic [QW-1:0]     num_reg, num_next;
    logic [RATE_W-1:0] dvs_reg, dvs_next;

    logic [NW-1:0]     num_full;
    logic [RATE_W:0]   shift_rem;
    logic [RATE_W+1:0] trial;
    logic              borrow;

    assign num_full  = {tick_rate, {(TICK_FRAC_BITS + HZ_FRAC_BITS){1'b0}}};
    assign shift_rem = {rem_reg, num_reg[QW-1]};
    assign trial     = {1'b0, shift_rem} - {2'b00, dvs_reg};
    assign borrow    = trial[RATE_W+1];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            DS_IDLE:
            begin
                if (start)
                    state_next = DS_RUN;
            end
            DS_RUN:
            begin
                if (cnt_reg == '0)
                    state_next = DS_IDLE;
            end
            default:
                state_next = DS_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        done = (state_reg == DS_RUN) && (cnt_reg == '0);
        quot = num_reg;
    end

    // Datapath: shift a numerator bit into the remainder, keep the quotient bit
    always_comb
    begin
        rem_next = rem_reg;
        num_next = num_reg;
        dvs_next = dvs_reg;
        cnt_next = cnt_reg;
        unique case (state_reg)
            DS_IDLE:
            begin
                if (start)
                begin
                    rem_next = RATE_W'(num_full[NW-1:QW]);
                    num_next = num_full[QW-1:0];
                    dvs_next = rate;
                    cnt_next = CNT_LAST;
                end
            end
            DS_RUN:
            begin
                rem_next = borrow ? shift_rem[RATE_W-1:0] : trial[RATE_W-1:0];
                num_next = {num_reg[QW-2:0], ~borrow};
                if (cnt_reg != '0)
                    cnt_next = cnt_reg - 1'b1;
            end
            default:
                ;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DS_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Operand registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        num_reg <= num_next;
        dvs_reg <= dvs_next;
    end

endmodule

/* rtl/trapezoid_step_interval_gen.sv */
`timescale 1ns / 1ps
// Top level of the trapezoid step interval generator: configuration
// registers, profile state, sequencer and rounding. Uses tsig_pkg,
// tsig_ramp_unit and tsig_div_unit.
//
// Each input word asks for the next stepper pulse interval; one result word
// comes back per input word. The rate follows a trapezoid (ramp from start to
// target over accel_ticks, cruise, ramp back over decel_ticks), is floored at
// 1 Hz, and the period tick_rate / rate is rounded half up with a carried
// fractional residual, clamped to [min_interval, max_interval] (max wins).
// Items are handled one at a time. On a ramp the sequencer first works out
// the ramp term with a 28-bit shift-add multiply and a 28-bit restoring
// divide, then runs the period divider; in cruise only the divider runs.
// Once elapsed time reaches the profile total a done word is sent without
// the ramp unit or the period divider. The input is ready again while a
// result still waits at the output.
// Write configuration only while no word is in flight.

module trapezoid_step_interval_gen
#(
    parameter int TICK_FRAC_BITS = tsig_pkg::TICK_FRAC_BITS_DEF,
    parameter int HZ_FRAC_BITS   = tsig_pkg::HZ_FRAC_BITS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [tsig_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tsig_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              restart,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [tsig_pkg::IVL_W-1:0]        pulse_interval,
    output logic [tsig_pkg::PHASE_W-1:0]      phase,
    output logic [tsig_pkg::HZ_OUT_W-1:0]     step_hz,
    output logic                              done_res
);
    import tsig_pkg::*;

    localparam int QW = TICK_RATE_W + TICK_FRAC_BITS;   // ideal period width
    localparam int SW = QW + 2;                         // rounding sum, signed
    localparam int DW = IVL_W + TICK_FRAC_BITS + 1;     // period error, signed
    localparam int RW = DW + 1;                         // new residual, signed
    localparam logic [RATE_W-1:0] HZ_ONE    = RATE_W'(1) << HZ_FRAC_BITS;
    localparam logic [SW-1:0]     HALF_TICK = SW'(1) << (TICK_FRAC_BITS - 1);

    // Configuration registers
    logic [RATE_W-1:0]      base_hz_reg;
    logic [RATE_W-1:0]      target_hz_reg;
    logic [SPAN_W-1:0]      accel_reg;
    logic [SPAN_W-1:0]      cruise_reg;
    logic [SPAN_W-1:0]      decel_reg;
    logic [IVL_W-1:0]       min_ivl_reg;
    logic [IVL_W-1:0]       max_ivl_reg;
    logic [TICK_RATE_W-1:0] tick_rate_reg;

    // Sequencer and profile state
    top_state_t                state_reg, state_next;
    logic [ELAPSED_W-1:0]      elapsed_reg, elapsed_next;
    logic signed [RES_W-1:0]   residual_reg, residual_next;

    // Working registers
    logic [SPAN_W:0]           ac_sum_reg, ac_sum_next;
    logic [PHASE_W-1:0]        kind_reg, kind_next;
    logic                      up_reg, up_next;
    logic [RATE_W-1:0]         r_reg, r_next;
    logic signed [SW-1:0]      sum_reg, sum_next;
    logic [IVL_W-1:0]          v_reg, v_next;
    logic signed [DW-1:0]      diff_reg, diff_next;
    logic [PHASE_W-1:0]        res_phase_reg, res_phase_next;
    logic [HZ_OUT_W-1:0]       res_hz_reg, res_hz_next;
    logic                      res_done_reg, res_done_next;

    // Output word
    logic                      out_valid_reg, out_valid_next;
    logic [IVL_W-1:0]          interval_reg;
    logic [PHASE_W-1:0]        phase_reg;
    logic [HZ_OUT_W-1:0]       hz_reg;
    logic                      done_reg;

    // Handshake and unit strobes
    logic                      in_accept;
    logic                      out_taken;
    logic                      slot_free;
    logic                      out_load;
    logic                      ramp_start;
    logic                      ramp_done;
    logic                      div_start;
    logic                      div_done;

    // Datapath helpers
    logic [ELAPSED_W-1:0]      total;
    logic                      is_done;
    logic                      in_accel;
    logic                      in_cruise;
    logic                      on_ramp;
    logic [ELAPSED_W-1:0]      dec_t;
    logic                      up_dir;
    logic [RATE_W-1:0]         mag;
    logic [SPAN_W-1:0]         ramp_t;
    logic [SPAN_W-1:0]         ramp_len;
    logic [RATE_W-1:0]         ramp_term;
    logic [RATE_W-1:0]         rate_raw;
    logic [RATE_W-1:0]         rate_floor;
    logic [RATE_W-1:0]         hz_full;
    logic [HZ_OUT_W-1:0]       hz_sat;
    logic [QW-1:0]             div_quot;
    logic [IVL_W-1:0]          v_round;
    logic [IVL_W-1:0]          v_low;
    logic [IVL_W-1:0]          v_clamp;
    logic [ELAPSED_W:0]        el_sum;
    logic signed [RW-1:0]      res_sum;
    logic                      res_fits;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_hz_reg   <= BASE_HZ_RST;
            target_hz_reg <= TARGET_HZ_RST;
            accel_reg     <= ACCEL_RST;
            cruise_reg    <= CRUISE_RST;
            decel_reg     <= DECEL_RST;
            min_ivl_reg   <= MIN_IVL_RST;
            max_ivl_reg   <= MAX_IVL_RST;
            tick_rate_reg <= TICK_RATE_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_BASE_HZ:   base_hz_reg   <= cfg_data[RATE_W-1:0];
                REG_TARGET_HZ: target_hz_reg <= cfg_data[RATE_W-1:0];
                REG_ACCEL:     accel_reg     <= cfg_data[SPAN_W-1:0];
                REG_CRUISE:    cruise_reg    <= cfg_data[SPAN_W-1:0];
                REG_DECEL:     decel_reg     <= cfg_data[SPAN_W-1:0];
                REG_MIN_IVL:   min_ivl_reg   <= cfg_data[IVL_W-1:0];
                REG_MAX_IVL:   max_ivl_reg   <= cfg_data[IVL_W-1:0];
                REG_TICK_RATE: tick_rate_reg <= cfg_data[TICK_RATE_W-1:0];
            endcase
        end
    end

    // Handshake
    assign in_accept = in_valid && !in_stall;
    assign out_taken = out_valid_reg && !out_stall;
    assign slot_free = !out_valid_reg || !out_stall;

    // Profile position: end of profile, phase and ramp operands
    assign total     = {1'b0, ac_sum_reg} + {2'b00, decel_reg};
    assign is_done   = elapsed_reg >= total;
    assign in_accel  = elapsed_reg < {2'b00, accel_reg};
    assign in_cruise = elapsed_reg < {1'b0, ac_sum_reg};
    assign on_ramp   = in_accel || !in_cruise;
    assign dec_t     = elapsed_reg - {1'b0, ac_sum_reg};
    assign up_dir    = target_hz_reg >= base_hz_reg;
    assign mag       = up_dir ? target_hz_reg - base_hz_reg
                              : base_hz_reg - target_hz_reg;
    assign ramp_t    = in_accel ? elapsed_reg[SPAN_W-1:0] : dec_t[SPAN_W-1:0];
    assign ramp_len  = in_accel ? accel_reg : decel_reg;

    // Rate on the trapezoid, floored at 1 Hz
    always_comb
    begin
        unique case (kind_reg)
            PHASE_ACCEL:
                rate_raw = up_reg ? base_hz_reg + ramp_term : base_hz_reg - ramp_term;
            PHASE_CRUISE:
                rate_raw = target_hz_reg;
            default:
                rate_raw = up_reg ? target_hz_reg - ramp_term : target_hz_reg + ramp_term;
        endcase
        rate_floor = (rate_raw < HZ_ONE) ? HZ_ONE : rate_raw;
    end

    // Integer step rate, saturated
    assign hz_full = r_reg >> HZ_FRAC_BITS;
    assign hz_sat  = (|hz_full[RATE_W-1:HZ_OUT_W]) ? {HZ_OUT_W{1'b1}}
                                                   : hz_full[HZ_OUT_W-1:0];

    // Round to whole ticks, then clamp: max wins over min
    assign v_round = sum_reg[SW-1] ? '0 : IVL_W'(sum_reg[SW-2:TICK_FRAC_BITS]);
    assign v_low   = (v_round < min_ivl_reg) ? min_ivl_reg : v_round;
    assign v_clamp = (v_low > max_ivl_reg) ? max_ivl_reg : v_low;

    // Advance time and carry the rounding error
    assign el_sum   = {1'b0, elapsed_reg} + (ELAPSED_W + 1)'(v_reg);
    assign res_sum  = RW'(residual_reg) + RW'(diff_reg);
    assign res_fits = (&res_sum[RW-1:RES_W-1]) || !(|res_sum[RW-1:RES_W-1]);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                    state_next = ST_SUM;
            end
            ST_SUM:
                state_next = ST_CHECK;
            ST_CHECK:
            begin
                if (is_done)
                    state_next = ST_EMIT;
                else if (on_ramp)
                    state_next = ST_RAMP;
                else
                    state_next = ST_RATE;
            end
            ST_RAMP:
            begin
                if (ramp_done)
                    state_next = ST_RATE;
            end
            ST_RATE:
                state_next = ST_LAUNCH;
            ST_LAUNCH:
                state_next = ST_DIV;
            ST_DIV:
            begin
                if (div_done)
                    state_next = ST_ROUND;
            end
            ST_ROUND:
                state_next = ST_CLAMP;
            ST_CLAMP:
                state_next = ST_UPDATE;
            ST_UPDATE:
                state_next = ST_FINISH;
            ST_FINISH:
                state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (slot_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        in_stall   = (state_reg != ST_IDLE);
        ramp_start = (state_reg == ST_CHECK) && !is_done && on_ramp;
        div_start  = (state_reg == ST_LAUNCH);
        out_load   = (state_reg == ST_EMIT) && slot_free;
    end

    // Datapath next values
    always_comb
    begin
        elapsed_next   = elapsed_reg;
        residual_next  = residual_reg;
        ac_sum_next    = ac_sum_reg;
        kind_next      = kind_reg;
        up_next        = up_reg;
        r_next         = r_reg;
        sum_next       = sum_reg;
        v_next         = v_reg;
        diff_next      = diff_reg;
        res_phase_next = res_phase_reg;
        res_hz_next    = res_hz_reg;
        res_done_next  = res_done_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                // drop time and residual on a restart word
                if (in_accept && restart)
                begin
                    elapsed_next  = '0;
                    residual_next = '0;
                end
            end
            ST_SUM:
                ac_sum_next = {1'b0, accel_reg} + {1'b0, cruise_reg};
            ST_CHECK:
            begin
                up_next = up_dir;
                if (is_done)
                begin
                    v_next         = '0;
                    res_phase_next = PHASE_DECEL;
                    res_hz_next    = '0;
                    res_done_next  = 1'b1;
                end
                else
                begin
                    res_done_next = 1'b0;
                    if (in_accel)
                        kind_next = PHASE_ACCEL;
                    else if (in_cruise)
                        kind_next = PHASE_CRUISE;
                    else
                        kind_next = PHASE_DECEL;
                end
            end
            ST_RATE:
                r_next = rate_floor;
            ST_LAUNCH:
                res_hz_next = hz_sat;
            ST_ROUND:
                sum_next = $signed({2'b00, div_quot}) + SW'(residual_reg)
                         + $signed(HALF_TICK);
            ST_CLAMP:
                v_next = v_clamp;
            ST_UPDATE:
            begin
                diff_next    = $signed(DW'(div_quot))
                             - $signed(DW'({v_reg, {TICK_FRAC_BITS{1'b0}}}));
                elapsed_next = el_sum[ELAPSED_W] ? {ELAPSED_W{1'b1}}
                                                 : el_sum[ELAPSED_W-1:0];
            end
            ST_FINISH:
            begin
                if (res_fits)
                    residual_next = res_sum[RES_W-1:0];
                else if (res_sum[RW-1])
                    residual_next = RES_MIN;
                else
                    residual_next = RES_MAX;
                // phase after the advance
                if (elapsed_reg < {2'b00, accel_reg})
                    res_phase_next = PHASE_ACCEL;
                else if (elapsed_reg < {1'b0, ac_sum_reg})
                    res_phase_next = PHASE_CRUISE;
                else
                    res_phase_next = PHASE_DECEL;
            end
            ST_RAMP, ST_DIV, ST_EMIT:
                ;
            default:
                ;
        endcase
    end

    // Output word valid: set on load, clear when taken
    always_comb
    begin
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_taken)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Control and profile state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            elapsed_reg   <= '0;
            residual_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            elapsed_reg   <= elapsed_next;
            residual_reg  <= residual_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        ac_sum_reg    <= ac_sum_next;
        kind_reg      <= kind_next;
        up_reg        <= up_next;
        r_reg         <= r_next;
        sum_reg       <= sum_next;
        v_reg         <= v_next;
        diff_reg      <= diff_next;
        res_phase_reg <= res_phase_next;
        res_hz_reg    <= res_hz_next;
        res_done_reg  <= res_done_next;
    end

    // Hold the result word until taken
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            interval_reg <= v_reg;
            phase_reg    <= res_phase_reg;
            hz_reg       <= res_hz_reg;
            done_reg     <= res_done_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign pulse_interval = interval_reg;
    assign phase          = phase_reg;
    assign step_hz        = hz_reg;
    assign done_res       = done_reg;

    // Ramp term: floor(|target - start| * t / len)
    tsig_ramp_unit u_ramp
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ramp_start),
        .mag   (mag),
        .t     (ramp_t),
        .len   (ramp_len),
        .done  (ramp_done),
        .term  (ramp_term)
    );

    // Ideal period in fractional ticks
    tsig_div_unit
    #(
        .TICK_FRAC_BITS (TICK_FRAC_BITS),
        .HZ_FRAC_BITS   (HZ_FRAC_BITS)
    )
    u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .tick_rate (tick_rate_reg),
        .rate      (r_reg),
        .done      (div_done),
        .quot      (div_quot)
    );

endmodule
